### design/swmm_pkg.sv
// Shared constants and types of the sliding-window minimum/maximum filter.
`default_nettype none

package swmm_pkg;

  localparam int WINDOW_MAX_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int CFG_W           = 7;
  localparam logic [CFG_W-1:0] WINDOW_LENGTH_RST = CFG_W'(1);

  typedef struct packed {
    logic shift;
    logic last;
    logic drain;
  } swmm_cell_ctl_t;

endpackage

`default_nettype wire

### design/swmm_cell.sv
// One cell of the window line: a stored sample plus a stage of the extreme-value scan.
`default_nettype none

module swmm_cell #(
  parameter int SAMPLE_BITS = swmm_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire swmm_pkg::swmm_cell_ctl_t      ctl,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_in,
  output logic signed [SAMPLE_BITS-1:0]      sample_out,
  input  wire logic                          tok_in_vld,
  input  wire logic signed [SAMPLE_BITS-1:0] tok_in_max,
  input  wire logic signed [SAMPLE_BITS-1:0] tok_in_min,
  output logic                               tok_out_vld,
  output logic signed [SAMPLE_BITS-1:0]      tok_out_max,
  output logic signed [SAMPLE_BITS-1:0]      tok_out_min,
  output logic                               fin_vld
);

  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic signed [SAMPLE_BITS-1:0] cur_sample;
  logic signed [SAMPLE_BITS-1:0] max_nxt;
  logic signed [SAMPLE_BITS-1:0] min_nxt;
  logic signed [SAMPLE_BITS-1:0] tok_max_r;
  logic signed [SAMPLE_BITS-1:0] tok_min_r;
  logic                          tok_vld_r;
  logic                          tok_vld_nxt;

  assign cur_sample  = ctl.shift ? sample_in : sample_r;
  assign max_nxt     = (cur_sample > tok_in_max) ? cur_sample : tok_in_max;
  assign min_nxt     = (cur_sample < tok_in_min) ? cur_sample : tok_in_min;
  assign tok_vld_nxt = tok_in_vld | (tok_vld_r & ctl.last & ~ctl.drain);

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      sample_r <= sample_in;
    end
    if (tok_in_vld) begin
      tok_max_r <= max_nxt;
      tok_min_r <= min_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_vld_r <= 1'b0;
    end else begin
      tok_vld_r <= tok_vld_nxt;
    end
  end

  assign sample_out  = sample_r;
  assign tok_out_vld = tok_vld_r & ~ctl.last;
  assign tok_out_max = tok_max_r;
  assign tok_out_min = tok_min_r;
  assign fin_vld     = tok_vld_r & ctl.last;

endmodule

`default_nettype wire

### design/sliding_window_min_max.sv
// Top level of the sliding-window minimum/maximum filter.
//
//   channel  | direction | tdata (low bit up)          | tuser
//   in_      | in        | sample                      | restart
//   out_     | out       | window_max, window_min      | -
//   cfg_     | in        | window_length (cfg_wr_data) | -
//
// A word that completes no window leaves the input ready for the next word; a word that
// yields a result stalls the input while its token walks one cell of the sample line per
// cycle to the last cell of the effective window. Reset clears the fill count, the scan
// tokens and the output valid bit and sets the window length to one. A stalled output
// holds the token in its final cell; the input waits until the result is handed on.
`default_nettype none

module sliding_window_min_max #(
  parameter int WINDOW_MAX  = swmm_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = swmm_pkg::SAMPLE_BITS_DEF,
  localparam int IN_W  = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [IN_W-1:0]            in_tdata,    // sample
  input  wire logic [0:0]                 in_tuser,    // restart
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  output logic [OUT_W-1:0]                out_tdata,   // window_max, window_min
  input  wire logic                       cfg_wr_en,
  input  wire logic [swmm_pkg::CFG_W-1:0] cfg_wr_data
);

  localparam int LW = $clog2(WINDOW_MAX + 1);

  logic [swmm_pkg::CFG_W-1:0]    wl_r;
  logic [LW-1:0]                 len_eff;
  logic [LW-1:0]                 fill_r;
  logic [LW-1:0]                 fill_nxt;
  logic                          in_acc;
  logic                          launch;
  logic                          drain;
  logic                          fin_any;
  logic                          tok_busy;
  logic signed [SAMPLE_BITS-1:0] in_sample;
  logic signed [SAMPLE_BITS-1:0] res_max;
  logic signed [SAMPLE_BITS-1:0] res_min;
  logic signed [SAMPLE_BITS-1:0] out_max_r;
  logic signed [SAMPLE_BITS-1:0] out_min_r;
  logic                          out_vld_r;

  logic signed [SAMPLE_BITS-1:0] smp   [WINDOW_MAX];
  logic                          t_vld [WINDOW_MAX];
  logic signed [SAMPLE_BITS-1:0] t_max [WINDOW_MAX];
  logic signed [SAMPLE_BITS-1:0] t_min [WINDOW_MAX];
  logic [WINDOW_MAX-1:0]         fin_vld;
  logic [WINDOW_MAX-1:0]         fwd_vld;
  swmm_pkg::swmm_cell_ctl_t      ctl   [WINDOW_MAX];

  assign in_sample = in_tdata[SAMPLE_BITS-1:0];
  assign in_acc    = in_tvalid & in_tready;
  assign drain     = ~out_vld_r | out_tready;
  assign fin_any   = |fin_vld;
  assign tok_busy  = |fwd_vld;
  assign in_tready = ~tok_busy & (~fin_any | drain);

  always_comb begin
    if (wl_r == '0) begin
      len_eff = LW'(1);
    end else if (32'(wl_r) > WINDOW_MAX) begin
      len_eff = LW'(WINDOW_MAX);
    end else begin
      len_eff = LW'(wl_r);
    end
  end

  always_comb begin
    if (in_tuser[0]) begin
      fill_nxt = LW'(1);
    end else if (fill_r == LW'(WINDOW_MAX)) begin
      fill_nxt = fill_r;
    end else begin
      fill_nxt = fill_r + LW'(1);
    end
  end

  assign launch = in_acc & (fill_nxt >= len_eff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wl_r   <= swmm_pkg::WINDOW_LENGTH_RST;
      fill_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        wl_r <= cfg_wr_data;
      end
      if (in_acc) begin
        fill_r <= fill_nxt;
      end
    end
  end

  for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_cell
    assign ctl[k].shift = in_acc;
    assign ctl[k].last  = ((k + 1) == int'(len_eff));
    assign ctl[k].drain = drain;

    if (k == 0) begin : g_head
      swmm_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl[k]),
        .sample_in   (in_sample),
        .sample_out  (smp[k]),
        .tok_in_vld  (launch),
        .tok_in_max  (in_sample),
        .tok_in_min  (in_sample),
        .tok_out_vld (fwd_vld[k]),
        .tok_out_max (t_max[k]),
        .tok_out_min (t_min[k]),
        .fin_vld     (fin_vld[k])
      );
    end else begin : g_body
      swmm_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl[k]),
        .sample_in   (smp[k-1]),
        .sample_out  (smp[k]),
        .tok_in_vld  (t_vld[k-1]),
        .tok_in_max  (t_max[k-1]),
        .tok_in_min  (t_min[k-1]),
        .tok_out_vld (fwd_vld[k]),
        .tok_out_max (t_max[k]),
        .tok_out_min (t_min[k]),
        .fin_vld     (fin_vld[k])
      );
    end
    assign t_vld[k] = fwd_vld[k];
  end

  always_comb begin
    res_max = '0;
    res_min = '0;
    for (int k = 0; k < WINDOW_MAX; k++) begin
      res_max = res_max | (fin_vld[k] ? t_max[k] : '0);
      res_min = res_min | (fin_vld[k] ? t_min[k] : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (fin_any && drain) begin
      out_max_r <= res_max;
      out_min_r <= res_min;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fin_any && drain) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = OUT_W'({out_min_r, out_max_r});

endmodule

`default_nettype wire

### design/swmm_checker.sv
// Port-level checker of the sliding-window minimum/maximum filter and its bind.
`default_nettype none

module swmm_checker #(
  parameter int SAMPLE_BITS = swmm_pkg::SAMPLE_BITS_DEF,
  localparam int OUT_W = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_tvalid,
  input wire logic                       in_tready,
  input wire logic                       out_tvalid,
  input wire logic                       out_tready,
  input wire logic [OUT_W-1:0]           out_tdata,
  input wire logic                       cfg_wr_en,
  input wire logic [swmm_pkg::CFG_W-1:0] cfg_wr_data
);

  logic [swmm_pkg::CFG_W-1:0] len_r;
  logic                       len_one;
  logic                       in_acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= swmm_pkg::WINDOW_LENGTH_RST;
    end else if (cfg_wr_en) begin
      len_r <= cfg_wr_data;
    end
  end

  assign len_one = (len_r == swmm_pkg::CFG_W'(0)) || (len_r == swmm_pkg::CFG_W'(1));
  assign in_acc  = in_tvalid & in_tready;

  // A waiting result keeps its value until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // Reset leaves the block empty and ready for a word.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> in_tready && !out_tvalid)
    else $error("block not empty after reset");

  // Window of one: an accepted word reaches out_tvalid via cell 0 and out_vld_r.
  a_len_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && len_one |=> ##1 out_tvalid)
    else $error("missing result for window length one");

  // With a window of one, the input waits only on a stalled result.
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    len_one && (!out_tvalid || out_tready) |-> in_tready)
    else $error("input stalled without cause");

endmodule

bind sliding_window_min_max swmm_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_swmm_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_tvalid   (in_tvalid),
  .in_tready   (in_tready),
  .out_tvalid  (out_tvalid),
  .out_tready  (out_tready),
  .out_tdata   (out_tdata),
  .cfg_wr_en   (cfg_wr_en),
  .cfg_wr_data (cfg_wr_data)
);

`default_nettype wire
